>>> rtl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and constants of the cartridge bank mapper
// Bus item, result, bank state and target codes.
// ----------------------------------------------------------------------------
`default_nettype none

package cbm_pkg;

   localparam int ADDR_W      = 16;
   localparam int DATA_W      = 8;
   localparam int MAP_W       = 22;
   localparam int TARGET_W    = 3;
   localparam int ROM_CNT_W   = 9;
   localparam int RAM_CNT_W   = 5;
   localparam int ROM_BANK_W  = 8;
   localparam int RAM_BANK_W  = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int CSR_INDEX_W = 1;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 32;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ROM_BANK_COUNT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAM_BANK_COUNT = 1'd1;

   localparam logic [ROM_CNT_W-1:0] ROM_CNT_RESET = 9'd2;
   localparam logic [RAM_CNT_W-1:0] RAM_CNT_RESET = 5'd0;

   // result targets
   localparam logic [TARGET_W-1:0] TGT_REG_WRITE = 3'd0;
   localparam logic [TARGET_W-1:0] TGT_ROM_READ  = 3'd1;
   localparam logic [TARGET_W-1:0] TGT_RAM_READ  = 3'd2;
   localparam logic [TARGET_W-1:0] TGT_RAM_WRITE = 3'd3;
   localparam logic [TARGET_W-1:0] TGT_OPEN_BUS  = 3'd4;
   localparam logic [TARGET_W-1:0] TGT_DROPPED   = 3'd5;
   localparam logic [TARGET_W-1:0] TGT_SYS_READ  = 3'd6;
   localparam logic [TARGET_W-1:0] TGT_SYS_WRITE = 3'd7;

   // register-write windows, selected by address bits 14:13
   localparam logic [1:0] WIN_RAM_ENABLE = 2'b00;
   localparam logic [1:0] WIN_ROM_BANK   = 2'b01;
   localparam logic [1:0] WIN_RAM_BANK   = 2'b10;
   localparam logic [1:0] WIN_MODE       = 2'b11;

   localparam logic [3:0]        RAM_ENABLE_KEY = 4'hA;
   localparam logic [DATA_W-1:0] OPEN_BUS_DATA  = 8'hFF;

   typedef struct packed {
      logic              command;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_data;
   } bus_item_type;

   typedef struct packed {
      logic [TARGET_W-1:0] target;
      logic [MAP_W-1:0]    mapped_address;
      logic [DATA_W-1:0]   data_out;
   } result_type;

   typedef struct packed {
      logic                  ram_enabled;
      logic [ROM_BANK_W-1:0] rom_sel;
      logic [RAM_BANK_W-1:0] ram_sel;
      logic                  bank_mode;
   } bank_state_type;

   typedef struct packed {
      logic [ROM_CNT_W-1:0] rom_bank_count;
      logic [RAM_CNT_W-1:0] ram_bank_count;
   } cfg_type;

endpackage

`default_nettype wire

>>> rtl/cartridge_bank_mapper.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper: cartridge ROM/RAM bank controller
// Translates CPU bus accesses into ROM, external RAM or system targets.
// ----------------------------------------------------------------------------
// A taken request is held in the input register; its result then moves into the
// result register, which drives the result channel.
// Throughput: 1 item per cycle while rsp_tready does not stall the result register;
// the decode is one short pass between registers. The bank state updates as an item
// moves into the result register, so the next item always sees it.
// Reset: synchronous, active high; clears bank state and valids, sets the
// bank counts to 2 ROM banks and 0 RAM banks.
`default_nettype none

module cartridge_bank_mapper
   import cbm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,   // [15:0] address, [23:16] write_data
   input  wire logic                   req_tuser,   // [0] command (1 = write)
   // result channel
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [RSP_DATA_W-1:0]  rsp_tdata,   // [21:0] mapped_address,
                                                    // [29:22] data_out, [31:30] zero
   output      logic [TARGET_W-1:0]    rsp_tuser,   // [2:0] target
   // configuration port
   input  wire logic                   csr_wen,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // input stage
   logic           in_valid_ff;
   bus_item_type   in_item_ff;
   // result stage
   logic           out_valid_ff;
   result_type     out_result_ff;

   bank_state_type state_ff;
   bank_state_type state_in;
   cfg_type        cfg_ff;
   result_type     result_in;

   logic out_free;
   logic in_move;
   logic req_take;

   // the result register frees when empty or when its item is taken
   assign out_free   = !out_valid_ff || rsp_tready;
   assign in_move    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || in_move;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.command    <= req_tuser;
         in_item_ff.address    <= req_tdata[ADDR_W-1:0];
         in_item_ff.write_data <= req_tdata[ADDR_W +: DATA_W];
      end
   end

   cbm_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .state_upd (in_move),
      .state_in  (state_in),
      .state_ff  (state_ff),
      .cfg_ff    (cfg_ff)
   );

   cbm_decode u_decode (
      .item       (in_item_ff),
      .state      (state_ff),
      .cfg        (cfg_ff),
      .result     (result_in),
      .state_next (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_move) begin
         out_result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_result_ff.target;
   assign rsp_tdata  = {2'b00, out_result_ff.data_out, out_result_ff.mapped_address};

endmodule

`default_nettype wire

>>> rtl/cbm_regs.sv
// ----------------------------------------------------------------------------
// cbm_regs: configuration and bank state registers
// Holds bank counts and the mapper's bank select state.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_regs
   import cbm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wen,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   state_upd,
   input  wire bank_state_type         state_in,
   output      bank_state_type         state_ff,
   output      cfg_type                cfg_ff
);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (state_upd) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rom_bank_count <= ROM_CNT_RESET;
         cfg_ff.ram_bank_count <= RAM_CNT_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_ROM_BANK_COUNT: cfg_ff.rom_bank_count <= csr_wdata[ROM_CNT_W-1:0];
            CSR_RAM_BANK_COUNT: cfg_ff.ram_bank_count <= csr_wdata[RAM_CNT_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> rtl/cbm_decode.sv
// ----------------------------------------------------------------------------
// cbm_decode: address decode and bank translation
// Maps one bus item to its result and the next bank state.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_decode
   import cbm_pkg::*;
(
   input  wire bus_item_type   item,
   input  wire bank_state_type state,
   input  wire cfg_type        cfg,
   output      result_type     result,
   output      bank_state_type state_next
);

   logic [ROM_BANK_W-1:0] rom_mask;
   logic [ROM_BANK_W-1:0] rom_bank_eff;
   logic [RAM_BANK_W-1:0] ram_bank_eff;
   logic                  in_ram_window;
   logic                  in_rom_window;
   logic                  ram_banking;

   always_comb begin
      rom_mask      = ROM_BANK_W'(cfg.rom_bank_count - 9'd1);
      rom_bank_eff  = (state.rom_sel == '0) ? 8'd1 : state.rom_sel;
      ram_bank_eff  = state.bank_mode ? state.ram_sel : 2'd0;
      in_ram_window = (item.address[15:13] == 3'b101);
      in_rom_window = (item.address[15:14] == 2'b01);
      ram_banking   = (cfg.ram_bank_count >= 5'd4);

      state_next = state;
      result.target         = TGT_SYS_READ;
      result.mapped_address = MAP_W'(item.address);
      result.data_out       = item.command ? item.write_data : '0;

      if (item.command) begin
         if (!item.address[15]) begin
            result.target = TGT_REG_WRITE;
            unique case (item.address[14:13])
               WIN_RAM_ENABLE:
                  state_next.ram_enabled = (item.write_data[3:0] == RAM_ENABLE_KEY);
               WIN_ROM_BANK:
                  state_next.rom_sel = item.write_data & rom_mask;
               WIN_RAM_BANK:
                  if (ram_banking) state_next.ram_sel = item.write_data[RAM_BANK_W-1:0];
               WIN_MODE:
                  state_next.bank_mode = item.write_data[0];
               default: ;
            endcase
         end else if (in_ram_window) begin
            if (state.ram_enabled) begin
               result.target         = TGT_RAM_WRITE;
               result.mapped_address = MAP_W'({ram_bank_eff, item.address[12:0]});
            end else begin
               result.target         = TGT_DROPPED;
               result.mapped_address = '0;
            end
         end else begin
            result.target = TGT_SYS_WRITE;
         end
      end else begin
         if (in_rom_window) begin
            result.target         = TGT_ROM_READ;
            result.mapped_address = {rom_bank_eff, item.address[13:0]};
         end else if (in_ram_window) begin
            if (state.ram_enabled) begin
               result.target         = TGT_RAM_READ;
               result.mapped_address = MAP_W'({ram_bank_eff, item.address[12:0]});
            end else begin
               result.target         = TGT_OPEN_BUS;
               result.mapped_address = '0;
               result.data_out       = OPEN_BUS_DATA;
            end
         end
      end
   end

endmodule

`default_nettype wire
